>>> rtl/vrgs_pkg.sv
package vrgs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CELL_BITS_DEF = 16;
    localparam int DIST_LIMIT    = 420;
    localparam int CLAMP_UNITS   = 32;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd3;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0] DIR_STILL = 2'b00;
    localparam logic [1:0] DIR_PLUS  = 2'b01;
    localparam logic [1:0] DIR_MINUS = 2'b10;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

>>> rtl/vrgs_if.sv
interface vrgs_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] through_x;
    logic [31:0] through_y;
    logic [31:0] through_z;

    modport source (output valid, req_type, start_x, start_y, start_z,
                    through_x, through_y, through_z, input ready);
    modport sink   (input valid, req_type, start_x, start_y, start_z,
                    through_x, through_y, through_z, output ready);
endinterface

interface vrgs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] voxel_x;
    logic [15:0] voxel_y;
    logic [15:0] voxel_z;
    logic [31:0] surface_u;
    logic [31:0] surface_v;
    logic [1:0]  crossed_axis;
    logic        in_bounds;
    logic        limit_reached;

    modport source (output valid, voxel_x, voxel_y, voxel_z, surface_u, surface_v,
                    crossed_axis, in_bounds, limit_reached, input ready);
    modport sink   (input valid, voxel_x, voxel_y, voxel_z, surface_u, surface_v,
                    crossed_axis, in_bounds, limit_reached, output ready);
endinterface

interface vrgs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/vrgs_mul.sv
module vrgs_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    output vrgs_pkg::t_unit_stat  o_stat,
    output logic [63:0]           o_prod
);
    import vrgs_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_acc;
    logic [31:0] r_mcand;
    logic [32:0] sum;

    // one multiplier bit per cycle, LSB first
    assign sum = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_mcand} : 33'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_acc   <= {32'd0, i_b};
                r_mcand <= i_a;
            end else if (r_busy) begin
                r_acc <= {sum, r_acc[31:1]};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;
endmodule

>>> rtl/vrgs_div.sv
module vrgs_div #(
    parameter int DIVD_W = 49
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVD_W-1:0]     i_num,
    input  logic [32:0]           i_den,
    output vrgs_pkg::t_unit_stat  o_stat,
    output logic [DIVD_W-1:0]     o_quo
);
    import vrgs_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [32:0]       r_rem;
    logic [32:0]       r_den;
    logic [DIVD_W-1:0] r_quo;
    logic [33:0]       rem_sh;
    logic              ge;
    logic [33:0]       rem_sub;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[32:0] : rem_sh[32:0];
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule

>>> rtl/voxel_ray_grid_stepper.sv
// Start transaction: the bit-serial divider forms the six slopes
// one quotient bit per cycle.
// Step transaction: the bit-serial multiplier forms two slope products and
// three squares per moving axis.
// One transaction in flight; the next is taken while a result waits in the output register.
// Synchronous active-low reset: grid 16x16x16, step limit 64, voxel 0, no motion.
module voxel_ray_grid_stepper #(
    parameter int FRAC_BITS = vrgs_pkg::FRAC_BITS_DEF,
    parameter int CELL_BITS = vrgs_pkg::CELL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vrgs_in_if.sink    i_req,
    vrgs_out_if.source o_res,
    vrgs_cfg_if.sink   i_cfg
);
    import vrgs_pkg::*;

    localparam int DIVD_W = 33 + FRAC_BITS;
    localparam int DIST_W = 2 * FRAC_BITS + 14;

    localparam logic signed [33:0] ONE_Q     = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] FRAC_MASK = ONE_Q - 34'sd1;
    localparam logic signed [33:0] CELL_HI   = (34'sd1 <<< (CELL_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] CELL_LO   = -CELL_HI - 34'sd1;
    localparam logic [32:0]        CLAMP_M   = 33'(CLAMP_UNITS) << FRAC_BITS;
    localparam logic [DIST_W-1:0]  BEST_INIT = DIST_W'(DIST_LIMIT) << (2 * FRAC_BITS);

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_SET  = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_AX_SET   = 4'd3;
    localparam logic [3:0] S_B_SET    = 4'd4;
    localparam logic [3:0] S_MUL_WAIT = 4'd5;
    localparam logic [3:0] S_SQ       = 4'd6;
    localparam logic [3:0] S_SQ_WAIT  = 4'd7;
    localparam logic [3:0] S_AX_END   = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX) return 32'sh7fffffff;
        else if (v < S32_MIN) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic [CELL_BITS-1:0] sat_cell(input logic signed [33:0] v);
        if (v > CELL_HI) return CELL_HI[CELL_BITS-1:0];
        else if (v < CELL_LO) return CELL_LO[CELL_BITS-1:0];
        else return v[CELL_BITS-1:0];
    endfunction

    function automatic logic [CELL_BITS-1:0] trunc_cell(input logic signed [31:0] s);
        logic [32:0]        m;
        logic [32:0]        q;
        logic signed [33:0] v;
        m = s[31] ? -{s[31], s} : {s[31], s};
        q = m >> FRAC_BITS;
        v = s[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sat_cell(v);
    endfunction

    function automatic logic [15:0] vox16(input logic [CELL_BITS-1:0] c);
        logic [31:0] e;
        e = {{(32 - CELL_BITS){c[CELL_BITS-1]}}, c};
        return e[15:0];
    endfunction

    function automatic logic in_rng(input logic [CELL_BITS-1:0] c, input logic [10:0] sz);
        return !c[CELL_BITS-1] &&
               ({{(34 - CELL_BITS){1'b0}}, c} < {23'd0, sz});
    endfunction

    function automatic logic [1:0] dir_code(input logic signed [32:0] d);
        if (d > 33'sd0) return DIR_PLUS;
        else if (d < 33'sd0) return DIR_MINUS;
        else return DIR_STILL;
    endfunction

    function automatic logic signed [31:0] pick3(input logic [1:0] k,
        input logic signed [31:0] x, input logic signed [31:0] y,
        input logic signed [31:0] z);
        case (k)
            AXIS_X:  return x;
            AXIS_Y:  return y;
            default: return z;
        endcase
    endfunction

    function automatic logic signed [32:0] pick3w(input logic [1:0] k,
        input logic signed [32:0] x, input logic signed [32:0] y,
        input logic signed [32:0] z);
        case (k)
            AXIS_X:  return x;
            AXIS_Y:  return y;
            default: return z;
        endcase
    endfunction

    // slope slot for motion axis a and cross axis b
    function automatic logic [2:0] slope_idx(input logic [1:0] a, input logic [1:0] b);
        case ({a, b})
            {AXIS_X, AXIS_Y}: return 3'd0;
            {AXIS_X, AXIS_Z}: return 3'd1;
            {AXIS_Y, AXIS_X}: return 3'd2;
            {AXIS_Y, AXIS_Z}: return 3'd3;
            {AXIS_Z, AXIS_X}: return 3'd4;
            default:          return 3'd5;
        endcase
    endfunction

    function automatic logic [1:0] den_axis(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: return AXIS_X;
            3'd2, 3'd3: return AXIS_Y;
            default:    return AXIS_Z;
        endcase
    endfunction

    function automatic logic [1:0] num_axis(input logic [2:0] k);
        case (k)
            3'd0, 3'd5: return AXIS_Y;
            3'd1, 3'd3: return AXIS_Z;
            default:    return AXIS_X;
        endcase
    endfunction

    logic [3:0]              r_state;
    logic [2:0]              r_k;
    logic [1:0]              r_a;
    logic [1:0]              r_b;
    logic                    r_is_start;
    logic [10:0]             r_grid_x, r_grid_y, r_grid_z;
    logic [15:0]             r_step_lim;
    logic [15:0]             r_step_cnt;
    logic [5:0]              r_signs;
    logic signed [31:0]      r_org_x, r_org_y, r_org_z;
    logic signed [31:0]      r_pt_x, r_pt_y, r_pt_z;
    logic [CELL_BITS-1:0]    r_cell_x, r_cell_y, r_cell_z;
    logic signed [32:0]      r_df_x, r_df_y, r_df_z;
    logic signed [31:0]      r_slope [6];
    logic                    r_div_neg;
    logic                    r_mneg;
    logic signed [33:0]      r_plane;
    logic signed [31:0]      r_run;
    logic signed [31:0]      r_cur_c;
    logic signed [31:0]      r_cand [3];
    logic signed [31:0]      r_best_c [3];
    logic [DIST_W-1:0]       r_dist;
    logic [DIST_W-1:0]       r_best;
    logic [1:0]              r_sel;
    logic                    r_sel_ok;

    logic                    r_out_valid;
    logic [15:0]             r_out_vx, r_out_vy, r_out_vz;
    logic [31:0]             r_out_u, r_out_v;
    logic [1:0]              r_out_axis;
    logic                    r_out_inb;
    logic                    r_out_lim;

    t_unit_stat              mul_stat;
    t_unit_stat              div_stat;
    logic                    mul_start;
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             mul_prod;
    logic                    div_start;
    logic [DIVD_W-1:0]       div_num;
    logic [32:0]             div_den;
    logic [DIVD_W-1:0]       div_quo;

    logic                    in_acc;
    logic [1:0]              dir_a;
    logic [1:0]              dir_sel;
    logic signed [31:0]      p_a, o_a, p_b, o_b;
    logic signed [33:0]      p_ext, fl, plane;
    logic signed [31:0]      run;
    logic signed [32:0]      df_den, df_num;
    logic [32:0]             den_mag, num_mag;
    logic signed [31:0]      div_sat;
    logic signed [31:0]      sel_slope;
    logic [31:0]             slope_mag, run_mag;
    logic [63:0]             prod_sh;
    logic signed [65:0]      prod_val;
    logic signed [31:0]      c_mul;
    logic signed [32:0]      diff;
    logic [32:0]             diff_mag, m_cl;
    logic signed [33:0]      cell_nx;

    assign in_acc = i_req.valid && i_req.ready;

    assign dir_a   = r_signs[2*r_a +: 2];
    assign dir_sel = r_signs[2*r_sel +: 2];
    assign p_a     = pick3(r_a, r_pt_x, r_pt_y, r_pt_z);
    assign o_a     = pick3(r_a, r_org_x, r_org_y, r_org_z);
    assign p_b     = pick3(r_b, r_pt_x, r_pt_y, r_pt_z);
    assign o_b     = pick3(r_b, r_org_x, r_org_y, r_org_z);

    // next plane in the direction of motion
    assign p_ext = {{2{p_a[31]}}, p_a};
    assign fl    = p_ext & ~FRAC_MASK;
    assign plane = (dir_a == DIR_PLUS) ? fl + ONE_Q :
                   ((|p_a[FRAC_BITS-1:0]) ? fl : p_ext - ONE_Q);
    assign run   = sat32(66'(plane) - 66'(o_a));

    assign df_den  = pick3w(den_axis(r_k), r_df_x, r_df_y, r_df_z);
    assign df_num  = pick3w(num_axis(r_k), r_df_x, r_df_y, r_df_z);
    assign den_mag = df_den[32] ? -df_den : df_den;
    assign num_mag = df_num[32] ? -df_num : df_num;

    always_comb begin
        if (r_div_neg) begin
            if ((|div_quo[DIVD_W-1:32]) || (div_quo[31] && (|div_quo[30:0])))
                div_sat = 32'sh80000000;
            else
                div_sat = -div_quo[31:0];
        end else begin
            if (|div_quo[DIVD_W-1:31])
                div_sat = 32'sh7fffffff;
            else
                div_sat = div_quo[31:0];
        end
    end

    assign sel_slope = r_slope[slope_idx(r_a, r_b)];
    assign slope_mag = sel_slope[31] ? -sel_slope : sel_slope;
    assign run_mag   = r_run[31] ? -r_run : r_run;
    assign prod_sh   = mul_prod >> FRAC_BITS;
    assign prod_val  = r_mneg ? -$signed({2'b00, prod_sh}) : $signed({2'b00, prod_sh});
    assign c_mul     = sat32(prod_val + 66'(o_b));

    assign diff     = 33'(r_cur_c) - 33'(p_b);
    assign diff_mag = diff[32] ? -diff : diff;
    assign m_cl     = (diff_mag > CLAMP_M) ? CLAMP_M : diff_mag;

    always_comb begin
        mul_start = 1'b0;
        mul_a     = m_cl[31:0];
        mul_b     = m_cl[31:0];
        div_start = (r_state == S_DIV_SET) && (df_den != 33'sd0);
        div_num   = {num_mag, {FRAC_BITS{1'b0}}};
        div_den   = den_mag;
        if (r_state == S_B_SET && r_b != r_a) begin
            mul_start = 1'b1;
            mul_a     = slope_mag;
            mul_b     = run_mag;
        end else if (r_state == S_SQ) begin
            mul_start = 1'b1;
        end
    end

    always_comb begin
        case (r_sel)
            AXIS_X:  cell_nx = 34'(signed'(r_cell_x));
            AXIS_Y:  cell_nx = 34'(signed'(r_cell_y));
            default: cell_nx = 34'(signed'(r_cell_z));
        endcase
        cell_nx = (dir_sel == DIR_PLUS) ? cell_nx + 34'sd1 : cell_nx - 34'sd1;
    end

    vrgs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    vrgs_div #(.DIVD_W(DIVD_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x   <= 11'd16;
            r_grid_y   <= 11'd16;
            r_grid_z   <= 11'd16;
            r_step_lim <= 16'd64;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_GRID_X:     r_grid_x   <= i_cfg.data[10:0];
                REG_GRID_Y:     r_grid_y   <= i_cfg.data[10:0];
                REG_GRID_Z:     r_grid_z   <= i_cfg.data[10:0];
                REG_STEP_LIMIT: r_step_lim <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_signs     <= 6'd0;
            r_step_cnt  <= 16'd0;
            r_cell_x    <= '0;
            r_cell_y    <= '0;
            r_cell_z    <= '0;
            r_pt_x      <= '0;
            r_pt_y      <= '0;
            r_pt_z      <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_is_start  <= 1'b0;
            r_sel_ok    <= 1'b0;
        end else begin
            // S_EMIT owns the valid flag in its own cycle
            if (o_res.ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_req.req_type) begin
                            r_is_start <= 1'b1;
                            r_org_x    <= i_req.start_x;
                            r_org_y    <= i_req.start_y;
                            r_org_z    <= i_req.start_z;
                            r_pt_x     <= i_req.start_x;
                            r_pt_y     <= i_req.start_y;
                            r_pt_z     <= i_req.start_z;
                            r_df_x     <= 33'(signed'(i_req.through_x)) - 33'(signed'(i_req.start_x));
                            r_df_y     <= 33'(signed'(i_req.through_y)) - 33'(signed'(i_req.start_y));
                            r_df_z     <= 33'(signed'(i_req.through_z)) - 33'(signed'(i_req.start_z));
                            r_signs    <= {dir_code(33'(signed'(i_req.through_z)) -
                                                    33'(signed'(i_req.start_z))),
                                           dir_code(33'(signed'(i_req.through_y)) -
                                                    33'(signed'(i_req.start_y))),
                                           dir_code(33'(signed'(i_req.through_x)) -
                                                    33'(signed'(i_req.start_x)))};
                            r_cell_x   <= trunc_cell(i_req.start_x);
                            r_cell_y   <= trunc_cell(i_req.start_y);
                            r_cell_z   <= trunc_cell(i_req.start_z);
                            r_step_cnt <= 16'd0;
                            r_k        <= 3'd0;
                            r_state    <= S_DIV_SET;
                        end else begin
                            r_is_start <= 1'b0;
                            r_step_cnt <= r_step_cnt + 16'd1;
                            r_a        <= AXIS_X;
                            r_best     <= BEST_INIT;
                            r_sel_ok   <= 1'b0;
                            r_state    <= S_AX_SET;
                        end
                    end
                end
                S_DIV_SET: begin
                    r_div_neg <= df_num[32] ^ df_den[32];
                    if (df_den == 33'sd0) begin
                        r_slope[r_k] <= '0;
                        r_k          <= r_k + 3'd1;
                        if (r_k == 3'd5) r_state <= S_FINISH;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        r_slope[r_k] <= div_sat;
                        r_k          <= r_k + 3'd1;
                        r_state      <= (r_k == 3'd5) ? S_FINISH : S_DIV_SET;
                    end
                end
                S_AX_SET: begin
                    if (dir_a == DIR_STILL) begin
                        r_a     <= r_a + 2'd1;
                        r_state <= (r_a == AXIS_Z) ? S_FINISH : S_AX_SET;
                    end else begin
                        r_plane <= plane;
                        r_run   <= run;
                        r_b     <= AXIS_X;
                        r_dist  <= '0;
                        r_state <= S_B_SET;
                    end
                end
                S_B_SET: begin
                    if (r_b == r_a) begin
                        r_cur_c <= sat32(66'(r_plane));
                        r_state <= S_SQ;
                    end else begin
                        r_mneg  <= sel_slope[31] ^ r_run[31];
                        r_state <= S_MUL_WAIT;
                    end
                end
                S_MUL_WAIT: begin
                    if (mul_stat.done) begin
                        r_cur_c <= c_mul;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cand[r_b] <= r_cur_c;
                    r_state     <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (mul_stat.done) begin
                        r_dist  <= r_dist + mul_prod[DIST_W-1:0];
                        r_b     <= r_b + 2'd1;
                        r_state <= (r_b == AXIS_Z) ? S_AX_END : S_B_SET;
                    end
                end
                S_AX_END: begin
                    // strict compare keeps the earlier axis on a tie
                    if (r_dist < r_best) begin
                        r_best      <= r_dist;
                        r_sel       <= r_a;
                        r_sel_ok    <= 1'b1;
                        r_best_c[0] <= r_cand[0];
                        r_best_c[1] <= r_cand[1];
                        r_best_c[2] <= r_cand[2];
                    end
                    r_a     <= r_a + 2'd1;
                    r_state <= (r_a == AXIS_Z) ? S_FINISH : S_AX_SET;
                end
                S_FINISH: begin
                    if (!r_is_start && r_sel_ok) begin
                        r_pt_x <= r_best_c[0];
                        r_pt_y <= r_best_c[1];
                        r_pt_z <= r_best_c[2];
                        case (r_sel)
                            AXIS_X:  r_cell_x <= sat_cell(cell_nx);
                            AXIS_Y:  r_cell_y <= sat_cell(cell_nx);
                            default: r_cell_z <= sat_cell(cell_nx);
                        endcase
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, loaded as the transaction leaves S_EMIT
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_out_valid || o_res.ready)) begin
            r_out_vx  <= vox16(r_cell_x);
            r_out_vy  <= vox16(r_cell_y);
            r_out_vz  <= vox16(r_cell_z);
            r_out_inb <= in_rng(r_cell_x, r_grid_x) && in_rng(r_cell_y, r_grid_y) &&
                         in_rng(r_cell_z, r_grid_z);
            r_out_lim <= !r_is_start && (r_step_cnt == r_step_lim);
            if (r_is_start || !r_sel_ok) begin
                r_out_axis <= AXIS_NONE;
                r_out_u    <= '0;
                r_out_v    <= '0;
            end else begin
                r_out_axis <= r_sel;
                case (r_sel)
                    AXIS_X: begin
                        r_out_u <= r_pt_y;
                        r_out_v <= r_pt_z;
                    end
                    AXIS_Y: begin
                        r_out_u <= r_pt_x;
                        r_out_v <= r_pt_z;
                    end
                    default: begin
                        r_out_u <= r_pt_x;
                        r_out_v <= r_pt_y;
                    end
                endcase
            end
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.voxel_x       = r_out_vx;
    assign o_res.voxel_y       = r_out_vy;
    assign o_res.voxel_z       = r_out_vz;
    assign o_res.surface_u     = r_out_u;
    assign o_res.surface_v     = r_out_v;
    assign o_res.crossed_axis  = r_out_axis;
    assign o_res.in_bounds     = r_out_inb;
    assign o_res.limit_reached = r_out_lim;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == S_MUL_WAIT || r_state == S_SQ_WAIT))
        else $error("multiplier finished outside a wait state");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");
endmodule

>>> tb/tb_voxel_ray_grid_stepper.sv
module tb_voxel_ray_grid_stepper;
    import vrgs_pkg::*;

    localparam int     FB        = FRAC_BITS_DEF;
    localparam longint ONE_Q     = longint'(1) << FB;
    localparam longint S32_HI    = 64'sd2147483647;
    localparam longint S32_LO    = -64'sd2147483648;
    localparam longint CELL_HI   = (longint'(1) << (CELL_BITS_DEF - 1)) - 1;
    localparam longint MAX_CYCLE = 4000000;

    typedef struct {
        logic [15:0] voxel_x;
        logic [15:0] voxel_y;
        logic [15:0] voxel_z;
        logic [31:0] surface_u;
        logic [31:0] surface_v;
        logic [1:0]  crossed_axis;
        logic        in_bounds;
        logic        limit_reached;
    } t_crossing;

    logic i_clk;
    logic i_rst_n;

    vrgs_in_if  req_if ();
    vrgs_out_if res_if ();
    vrgs_cfg_if cfg_if ();

    voxel_ray_grid_stepper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    longint      ray_org [3];
    longint      ray_pnt [3];
    longint      ray_cell[3];
    logic [1:0]  ray_dir [3];
    longint      slopes  [6];
    logic [15:0] step_cnt;
    longint      grid_sz [3];
    logic [15:0] step_lim;

    t_crossing crossing_q[$];
    int        fail_cnt;
    longint    cycle_cnt;
    bit        calm;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint trunc_unit(longint v);
        return v < 0 ? -((-v) >>> FB) : (v >>> FB);
    endfunction

    function automatic longint mul_fix(longint a, longint b);
        longint p;
        p = (absv(a) * absv(b)) >>> FB;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint slope_fix(longint num, longint den);
        longint q;
        q = (absv(num) <<< FB) / absv(den);
        if ((num < 0) != (den < 0))
            return q > 64'sd2147483648 ? S32_LO : -q;
        return q > S32_HI ? S32_HI : q;
    endfunction

    // dy/dx, dz/dx, dx/dy, dz/dy, dx/dz, dy/dz
    function automatic int slope_idx(int a, int b);
        return 2 * a + ((b > a) ? b - 1 : b);
    endfunction

    function automatic t_crossing make_crossing(logic [1:0] ax, longint u, longint v,
                                                logic lim);
        t_crossing r;
        r.voxel_x       = ray_cell[0][15:0];
        r.voxel_y       = ray_cell[1][15:0];
        r.voxel_z       = ray_cell[2][15:0];
        r.surface_u     = u[31:0];
        r.surface_v     = v[31:0];
        r.crossed_axis  = ax;
        r.in_bounds     = 1'b1;
        for (int a = 0; a < 3; a++)
            if (ray_cell[a] < 0 || ray_cell[a] >= grid_sz[a])
                r.in_bounds = 1'b0;
        r.limit_reached = lim;
        return r;
    endfunction

    task automatic reset_model();
        for (int a = 0; a < 3; a++) begin
            ray_org[a]  = 0;
            ray_pnt[a]  = 0;
            ray_cell[a] = 0;
            ray_dir[a]  = DIR_STILL;
            grid_sz[a]  = 16;
        end
        for (int k = 0; k < 6; k++)
            slopes[k] = 0;
        step_cnt = '0;
        step_lim = 16'd64;
    endtask

    task automatic predict_crossing(logic rt, logic [31:0] s[3], logic [31:0] t[3]);
        longint df[3];
        longint cand[3];
        longint best[3];
        longint bestd;
        longint sq_dist;
        longint frac;
        longint fl;
        longint plane;
        longint run;
        longint m;
        int     sel;
        logic   lim;
        if (!rt) begin
            for (int a = 0; a < 3; a++) begin
                df[a] = longint'($signed(t[a])) - longint'($signed(s[a]));
                ray_dir[a] = df[a] > 0 ? DIR_PLUS : (df[a] < 0 ? DIR_MINUS : DIR_STILL);
            end
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    if (a != b)
                        slopes[slope_idx(a, b)] = df[a] != 0 ? slope_fix(df[b], df[a]) : 0;
            for (int a = 0; a < 3; a++) begin
                ray_org[a]  = longint'($signed(s[a]));
                ray_pnt[a]  = ray_org[a];
                ray_cell[a] = sat(trunc_unit(ray_org[a]), -CELL_HI - 1, CELL_HI);
            end
            step_cnt = '0;
            crossing_q.push_back(make_crossing(AXIS_NONE, 0, 0, 1'b0));
            return;
        end
        bestd = longint'(DIST_LIMIT) <<< (2 * FB);
        sel   = -1;
        for (int a = 0; a < 3; a++) begin
            if (ray_dir[a] == DIR_STILL)
                continue;
            frac  = ray_pnt[a] & (ONE_Q - 1);
            fl    = ray_pnt[a] - frac;
            plane = (ray_dir[a] == DIR_PLUS) ? fl + ONE_Q
                                             : ((frac != 0) ? fl + ONE_Q : ray_pnt[a]) - ONE_Q;
            run   = sat(plane - ray_org[a], S32_LO, S32_HI);
            sq_dist = 0;
            for (int b = 0; b < 3; b++) begin
                if (b == a)
                    cand[b] = sat(plane, S32_LO, S32_HI);
                else
                    cand[b] = sat(mul_fix(slopes[slope_idx(a, b)], run) + ray_org[b],
                                  S32_LO, S32_HI);
                m = absv(cand[b] - ray_pnt[b]);
                if (m > (longint'(CLAMP_UNITS) <<< FB))
                    m = longint'(CLAMP_UNITS) <<< FB;
                sq_dist += m * m;
            end
            if (sq_dist < bestd) begin
                bestd = sq_dist;
                sel   = a;
                best  = cand;
            end
        end
        step_cnt = step_cnt + 16'd1;
        lim      = (step_cnt == step_lim);
        if (sel < 0) begin
            crossing_q.push_back(make_crossing(AXIS_NONE, 0, 0, lim));
            return;
        end
        ray_pnt = best;
        ray_cell[sel] = sat(ray_cell[sel] + ((ray_dir[sel] == DIR_PLUS) ? 1 : -1),
                            -CELL_HI - 1, CELL_HI);
        case (sel)
            0: crossing_q.push_back(make_crossing(AXIS_X, ray_pnt[1], ray_pnt[2], lim));
            1: crossing_q.push_back(make_crossing(AXIS_Y, ray_pnt[0], ray_pnt[2], lim));
            default: crossing_q.push_back(make_crossing(AXIS_Z, ray_pnt[0], ray_pnt[1], lim));
        endcase
    endtask

    // one request transaction; starts at a falling edge and ends at the rising edge that accepts it
    task automatic send_req(logic rt, logic [31:0] s[3], logic [31:0] t[3]);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 8) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.req_type  = rt;
        req_if.start_x   = s[0];
        req_if.start_y   = s[1];
        req_if.start_z   = s[2];
        req_if.through_x = t[0];
        req_if.through_y = t[1];
        req_if.through_z = t[2];
        do @(posedge i_clk); while (!req_if.ready);
        predict_crossing(rt, s, t);
    endtask

    task automatic start_ray(logic [31:0] s[3], logic [31:0] t[3]);
        send_req(1'b0, s, t);
    endtask

    task automatic step_ray(int n);
        logic [31:0] junk[3];
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++)
                junk[a] = $urandom;
            send_req(1'b1, junk, junk);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (crossing_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_GRID_X:     grid_sz[0] = val[10:0];
            REG_GRID_Y:     grid_sz[1] = val[10:0];
            REG_GRID_Z:     grid_sz[2] = val[10:0];
            REG_STEP_LIMIT: step_lim   = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_grid(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                            logic [15:0] lim);
        wait_drain();
        write_reg(REG_GRID_X, gx);
        write_reg(REG_GRID_Y, gy);
        write_reg(REG_GRID_Z, gz);
        write_reg(REG_STEP_LIMIT, lim);
    endtask

    function automatic logic [31:0] q_units(int units, int frac);
        return 32'(longint'(units) * ONE_Q + frac);
    endfunction

    task automatic test_reset_state();
        logic [31:0] s[3];
        logic [31:0] t[3];
        // no motion after reset: steps find no candidate
        step_ray(2);
        for (int a = 0; a < 3; a++) begin
            s[a] = q_units(2, 32768);
            t[a] = s[a];
        end
        start_ray(s, t);
        step_ray(1);
    endtask

    task automatic test_directed();
        logic [31:0] s[3];
        logic [31:0] t[3];
        // field extremes, slopes saturate
        s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
        start_ray(s, t);
        step_ray(3);
        s = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        start_ray(s, t);
        step_ray(2);
        // voxel saturation at the top of the index range
        s = '{32'h7FFF_8000, 32'h0001_0000, 32'h0001_0000};
        t = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000};
        start_ray(s, t);
        step_ray(2);
        // negative start truncates toward zero, integer point moving minus
        s = '{q_units(-3, 0), q_units(-1, 16384), q_units(4, 0)};
        t = '{q_units(-6, 0), q_units(-1, 16384), q_units(1, 0)};
        start_ray(s, t);
        step_ray(3);
        // diagonal from voxel centers: distance ties
        s = '{q_units(5, 32768), q_units(5, 32768), q_units(5, 32768)};
        t = '{q_units(6, 32768), q_units(6, 32768), q_units(6, 32768)};
        start_ray(s, t);
        step_ray(3);
        // long step along a shallow axis lies beyond the distance limit
        s = '{q_units(0, 100), q_units(0, 100), q_units(0, 100)};
        t = '{q_units(0, 101), q_units(100, 0), q_units(0, 100)};
        start_ray(s, t);
        step_ray(2);
    endtask

    task automatic test_config();
        logic [31:0] s[3];
        logic [31:0] t[3];
        set_grid(16'd1, 16'd1024, 16'd0, 16'd1);
        s = '{q_units(0, 1000), q_units(1023, 0), q_units(0, 0)};
        t = '{q_units(1, 0), q_units(1024, 0), q_units(-1, 0)};
        start_ray(s, t);
        step_ray(3);
        // indexes above the last register do nothing
        wait_drain();
        for (int i = 4; i < 8; i++)
            write_reg(3'(i), 16'hFFFF);
        set_grid(16'hFFFF, 16'h07FF, 16'd1024, 16'd65535);
        start_ray(s, t);
        step_ray(2);
        set_grid(16'd16, 16'd16, 16'd16, 16'd5);
    endtask

    task automatic make_ray(output logic [31:0] s[3], output logic [31:0] t[3]);
        int d;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(99) < 8) begin
                s[a] = $urandom;
                t[a] = $urandom;
            end else begin
                s[a] = q_units($urandom_range(24) - 4, $urandom_range(65535));
                case ($urandom_range(5))
                    0: d = 0;
                    1: d = int'($urandom_range(65535)) - 32768;
                    default: d = int'($urandom_range(6 * 65536)) - 3 * 65536;
                endcase
                t[a] = s[a] + 32'(d);
            end
        end
    endtask

    task automatic test_random_rays(int budget);
        logic [31:0] s[3];
        logic [31:0] t[3];
        int n;
        int done;
        done = 0;
        while (done < budget) begin
            calm = (done > budget / 3 && done < budget / 2);
            if (done > 2 * budget / 3 && done < 2 * budget / 3 + 30)
                wait_drain();
            make_ray(s, t);
            start_ray(s, t);
            n = $urandom_range(20, 1);
            step_ray(n);
            done += n + 1;
        end
        calm = 1'b0;
    endtask

    always @(negedge i_clk)
        res_if.ready <= calm || ($urandom_range(99) >= 8);

    always @(posedge i_clk) begin
        t_crossing e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (crossing_q.size() == 0) begin
                $error("result with no expectation waiting");
                fail_cnt++;
            end else begin
                e = crossing_q.pop_front();
                if (res_if.voxel_x !== e.voxel_x) begin
                    $error("voxel_x exp %h got %h", e.voxel_x, res_if.voxel_x);
                    fail_cnt++;
                end
                if (res_if.voxel_y !== e.voxel_y) begin
                    $error("voxel_y exp %h got %h", e.voxel_y, res_if.voxel_y);
                    fail_cnt++;
                end
                if (res_if.voxel_z !== e.voxel_z) begin
                    $error("voxel_z exp %h got %h", e.voxel_z, res_if.voxel_z);
                    fail_cnt++;
                end
                if (res_if.surface_u !== e.surface_u) begin
                    $error("surface_u exp %h got %h", e.surface_u, res_if.surface_u);
                    fail_cnt++;
                end
                if (res_if.surface_v !== e.surface_v) begin
                    $error("surface_v exp %h got %h", e.surface_v, res_if.surface_v);
                    fail_cnt++;
                end
                if (res_if.crossed_axis !== e.crossed_axis) begin
                    $error("crossed_axis exp %0d got %0d", e.crossed_axis,
                           res_if.crossed_axis);
                    fail_cnt++;
                end
                if (res_if.in_bounds !== e.in_bounds) begin
                    $error("in_bounds exp %b got %b", e.in_bounds, res_if.in_bounds);
                    fail_cnt++;
                end
                if (res_if.limit_reached !== e.limit_reached) begin
                    $error("limit_reached exp %b got %b", e.limit_reached,
                           res_if.limit_reached);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        fail_cnt         = 0;
        cycle_cnt        = 0;
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = 1'b0;
        req_if.start_x   = '0;
        req_if.start_y   = '0;
        req_if.start_z   = '0;
        req_if.through_x = '0;
        req_if.through_y = '0;
        req_if.through_z = '0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        reset_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_config();
        test_random_rays(450);
        set_grid(16'd1, 16'd3, 16'd1024, 16'd1);
        test_random_rays(200);
        set_grid(16'd16, 16'd16, 16'd16, 16'd7);
        test_random_rays(200);

        wait_drain();
        repeat (600) @(posedge i_clk);
        if (fail_cnt == 0 && crossing_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
